[rtl/core/lcm_pkg.sv]
// ----------------------------------------------------------------------------
// lcm_pkg
// shared codes and types of the lru cache tag model
// ----------------------------------------------------------------------------
package lcm_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

	// access commands
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_MODIFY = 2'd2;

	typedef struct packed {
		logic [1:0] hit_count;
		logic       missed;
		logic       evicted;
	} res_t;

endpackage

[rtl/core/lru_cache_hit_miss_model.sv]
// ----------------------------------------------------------------------------
// lru_cache_hit_miss_model
// tag side of a set-associative cache with lru replacement
// ----------------------------------------------------------------------------
// an accepted item's set row is read into a register and updated while busy; the result is then registered
// a new item is taken only while busy is low, during the read then write of the set memory it is not
// busy is high for the one cycle the set row is read back and updated
// results come with done for one cycle; the receiver cannot stall
// reset empties every set at once through per-row flags, no clearing pass
module lru_cache_hit_miss_model import lcm_pkg::*; #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            command,
	input  logic [63:0]           address,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [1:0]            hit_count,
	output logic                  missed,
	output logic                  evicted
);

	localparam int SET_BITS_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CW = $clog2(MAX_WAYS + 1);
	localparam logic [3:0] SB_MAX   = 4'(SET_BITS_MAX);
	localparam logic [4:0] WAYS_MAX = 5'(MAX_WAYS);

	logic [3:0] set_bits_q;
	logic [4:0] offset_bits_q;
	logic [3:0] ways_q;

	logic                 accept;
	logic [3:0]           sbits_eff;
	logic [CW-1:0]        ways_eff;
	logic [ADDR_BITS-1:0] addr_m;
	logic [ADDR_BITS-1:0] shifted;
	logic [SW-1:0]        set_idx;
	logic [ADDR_BITS-1:0] tag_in;

	logic                 valid_s1;
	logic [SW-1:0]        set_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic [1:0]           cmd_s1;

	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] rd_tags, wr_tags;
	logic [MAX_WAYS-1:0][WW-1:0]        rd_ranks, wr_ranks;
	logic [CW-1:0]                      rd_fill, wr_fill;
	res_t                               res_d;
	res_t                               res_q;
	logic                               done_q;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign busy      = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= '0;
			offset_bits_q <= '0;
			ways_q        <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SET_BITS:    set_bits_q    <= cfg_data[3:0];
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_WAYS:        ways_q        <= cfg_data[3:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		sbits_eff = (set_bits_q > SB_MAX) ? SB_MAX : set_bits_q;
		if (ways_q == 4'd0) begin
			ways_eff = CW'(1);
		end else if ({1'b0, ways_q} > WAYS_MAX) begin
			ways_eff = CW'(WAYS_MAX);
		end else begin
			ways_eff = CW'(ways_q);
		end
	end

	assign addr_m  = address[ADDR_BITS-1:0];
	assign shifted = addr_m >> offset_bits_q;
	assign set_idx = shifted[SW-1:0] & ~({SW{1'b1}} << sbits_eff);
	assign tag_in  = shifted >> sbits_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_idx;
			tag_s1 <= tag_in;
			cmd_s1 <= command;
		end
		if (valid_s1) begin
			res_q <= res_d;
		end
	end

	lcm_set_mem #(
		.SETS (MAX_SETS),
		.WAYS (MAX_WAYS),
		.TW   (ADDR_BITS),
		.SW   (SW),
		.WW   (WW),
		.CW   (CW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (set_idx),
		.rd_tags  (rd_tags),
		.rd_ranks (rd_ranks),
		.rd_fill  (rd_fill),
		.wr_en    (valid_s1),
		.wr_addr  (set_s1),
		.wr_tags  (wr_tags),
		.wr_ranks (wr_ranks),
		.wr_fill  (wr_fill)
	);

	lcm_update #(
		.WAYS (MAX_WAYS),
		.TW   (ADDR_BITS),
		.WW   (WW),
		.CW   (CW)
	) u_update (
		.old_tags  (rd_tags),
		.old_ranks (rd_ranks),
		.old_fill  (rd_fill),
		.tag       (tag_s1),
		.command   (cmd_s1),
		.ways_eff  (ways_eff),
		.new_tags  (wr_tags),
		.new_ranks (wr_ranks),
		.new_fill  (wr_fill),
		.res       (res_d)
	);

	assign done      = done_q;
	assign hit_count = res_q.hit_count;
	assign missed    = res_q.missed;
	assign evicted   = res_q.evicted;

	// every access either hits or misses
	a_hit_or_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (missed || hit_count != 2'd0))
		else $error("result with neither hit nor miss");

	// an eviction only follows a miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> missed)
		else $error("eviction without miss");

	// a result follows the update cycle
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without update cycle");

	// the row update takes a single cycle
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

endmodule

[rtl/core/lcm_set_mem.sv]
// ----------------------------------------------------------------------------
// lcm_set_mem
// set memory: one row per set holding fill count, ranks and tags of all ways,
// with a registered read and a flop per row that marks it as written
// ----------------------------------------------------------------------------
module lcm_set_mem import lcm_pkg::*; #(
	parameter int SETS = 256,
	parameter int WAYS = 8,
	parameter int TW   = 64,
	parameter int SW   = 8,
	parameter int WW   = 3,
	parameter int CW   = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [SW-1:0]                 rd_addr,
	output logic [WAYS-1:0][TW-1:0]       rd_tags,
	output logic [WAYS-1:0][WW-1:0]       rd_ranks,
	output logic [CW-1:0]                 rd_fill,
	input  logic                          wr_en,
	input  logic [SW-1:0]                 wr_addr,
	input  logic [WAYS-1:0][TW-1:0]       wr_tags,
	input  logic [WAYS-1:0][WW-1:0]       wr_ranks,
	input  logic [CW-1:0]                 wr_fill
);

	localparam int RW = CW + WAYS * WW + WAYS * TW;

	logic [RW-1:0]   mem [SETS];
	logic [RW-1:0]   rd_row_q;
	logic [SETS-1:0] row_vld_q;
	logic            rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_fill, wr_ranks, wr_tags};
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// a row never written reads as an empty set
	assign rd_tags  = rd_row_q[WAYS*TW-1:0];
	assign rd_ranks = rd_row_q[WAYS*TW +: WAYS*WW];
	assign rd_fill  = rd_vld_q ? rd_row_q[RW-1 -: CW] : '0;

endmodule

[rtl/core/lcm_update.sv]
// ----------------------------------------------------------------------------
// lcm_update
// tag lookup and lru update of one set row, plus the access result
// ----------------------------------------------------------------------------
module lcm_update import lcm_pkg::*; #(
	parameter int WAYS = 8,
	parameter int TW   = 64,
	parameter int WW   = 3,
	parameter int CW   = 4
) (
	input  logic [WAYS-1:0][TW-1:0] old_tags,
	input  logic [WAYS-1:0][WW-1:0] old_ranks,
	input  logic [CW-1:0]           old_fill,
	input  logic [TW-1:0]           tag,
	input  logic [1:0]              command,
	input  logic [CW-1:0]           ways_eff,
	output logic [WAYS-1:0][TW-1:0] new_tags,
	output logic [WAYS-1:0][WW-1:0] new_ranks,
	output logic [CW-1:0]           new_fill,
	output res_t                    res
);

	logic [WAYS-1:0] line_vld;
	logic [WAYS-1:0] hit_vec;
	logic            hit;
	logic            fill_mode;
	logic [WW-1:0]   hit_way;
	logic [WW-1:0]   worst_way;
	logic [WW-1:0]   worst_rank;
	logic [WW-1:0]   sel_way;
	logic [CW-1:0]   old_rank;

	always_comb begin
		hit_way    = '0;
		worst_way  = '0;
		worst_rank = '0;
		for (int i = 0; i < WAYS; i++) begin
			line_vld[i] = int'(old_fill) > i;
			hit_vec[i]  = line_vld[i] && (old_tags[i] == tag);
		end
		// lowest matching way wins
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_way = WW'(i);
			end
		end
		// highest rank, later way wins a tie
		for (int i = 0; i < WAYS; i++) begin
			if (line_vld[i] && old_ranks[i] >= worst_rank) begin
				worst_rank = old_ranks[i];
				worst_way  = WW'(i);
			end
		end
		hit       = |hit_vec;
		fill_mode = old_fill < ways_eff;

		if (hit) begin
			sel_way  = hit_way;
			old_rank = CW'(old_ranks[hit_way]);
			new_fill = old_fill;
		end else if (fill_mode) begin
			sel_way  = old_fill[WW-1:0];
			old_rank = old_fill;
			new_fill = old_fill + 1'b1;
		end else begin
			sel_way  = worst_way;
			old_rank = CW'(worst_rank);
			new_fill = old_fill;
		end

		for (int i = 0; i < WAYS; i++) begin
			new_tags[i] = (!hit && sel_way == WW'(i)) ? tag : old_tags[i];
			if (sel_way == WW'(i)) begin
				new_ranks[i] = '0;
			end else if (int'(new_fill) > i && CW'(old_ranks[i]) < old_rank) begin
				new_ranks[i] = old_ranks[i] + 1'b1;
			end else begin
				new_ranks[i] = old_ranks[i];
			end
		end

		res.hit_count = {1'b0, hit} + ((command == CMD_MODIFY) ? 2'd1 : 2'd0);
		res.missed    = !hit;
		res.evicted   = !hit && !fill_mode;
	end

endmodule
